// File: hdl/time_signature_map_assert.svh
`ifndef TIME_SIGNATURE_MAP_ASSERT_SVH
`define TIME_SIGNATURE_MAP_ASSERT_SVH

// Checks a condition that must hold in the same cycle as its trigger.
`define TSM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("time_signature_map check failed");

// Checks a condition that must hold in the cycle after its trigger.
`define TSM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("time_signature_map check failed");

`endif

// File: hdl/tsm_pkg.sv
package tsm_pkg;

   localparam int MAX_CHANGES     = 64;
   localparam int IDX_W           = $clog2(MAX_CHANGES);
   localparam int CNT_W           = $clog2(MAX_CHANGES + 1);
   localparam int TICKS_PER_WHOLE = 1920;
   localparam int TICKS_PER_BEAT  = 480;
   localparam int DIVD_W          = 35;
   localparam int DIVS_W          = 19;
   localparam int DIV_CNT_W       = $clog2(DIVD_W);

   typedef logic [CNT_W-1:0]     count_type;
   typedef logic [IDX_W-1:0]     index_type;
   typedef logic [DIVD_W-1:0]    dividend_type;
   typedef logic [DIVS_W-1:0]    divisor_type;
   typedef logic [DIV_CNT_W-1:0] div_count_type;

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_FWD = 2'd1;
   localparam logic [1:0] FUNC_REV = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_REPEAT    = 3'd1;
   localparam logic [2:0] ST_NOT_INCR  = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_ZERO_SIG  = 3'd4;

   typedef struct packed {
      logic [15:0] measure;
      logic [7:0]  num;
      logic [7:0]  denom;
      logic [31:0] start;
   } sig_entry_type;

   typedef struct packed {
      logic         start;
      dividend_type dividend;
      divisor_type  divisor;
   } div_req_type;

   typedef struct packed {
      logic         done;
      dividend_type quotient;
      divisor_type  remainder;
   } div_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ADD_RD,
      S_ADD_CHK,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_MUL,
      S_DIV_GO,
      S_DIV_WAIT,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_SPAN,
      PH_LEN,
      PH_MEAS,
      PH_BEAT,
      PH_BPM
   } phase_type;

endpackage

// File: hdl/tsm_div.sv
module tsm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tsm_pkg::div_req_type div_req,
   output tsm_pkg::div_rsp_type div_rsp
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   tsm_pkg::div_count_type cnt_ff, cnt_in;
   tsm_pkg::dividend_type  quo_ff, quo_in;
   tsm_pkg::divisor_type   rem_ff, rem_in;
   tsm_pkg::divisor_type   dvs_ff, dvs_in;
   logic [tsm_pkg::DIVS_W:0]   shifted;
   logic [tsm_pkg::DIVS_W+1:0] trial;
   logic                       fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[tsm_pkg::DIVD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      fits    = ~trial[tsm_pkg::DIVS_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = tsm_pkg::div_count_type'(tsm_pkg::DIVD_W - 1);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[tsm_pkg::DIVD_W-2:0], fits};
         rem_in = fits ? trial[tsm_pkg::DIVS_W-1:0] : shifted[tsm_pkg::DIVS_W-1:0];
         cnt_in = cnt_ff - tsm_pkg::div_count_type'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// File: hdl/time_signature_map.sv
// Time-signature map at 480 ticks per beat. One request is taken at a time and req_stall
// stays high until its response has been registered. Every division runs on a single
// restoring divider that produces one quotient bit a cycle. Adding a signature needs one
// division; it needs none when it is refused for a zero field or as a repeated start
// signature, or replaces the first entry, or when the measure does not increase or the
// table is full. A measure-to-tick conversion scans the table entries and then needs one
// division. A tick-to-measure conversion scans the table entries and needs four divisions.
// The table is a 64-entry memory with one registered read port.
module time_signature_map (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [15:0]        req_measure_in,
   input  logic [7:0]         req_beat_in,
   input  logic [30:0]        req_tick_in,
   input  logic [7:0]         req_sig_numerator,
   input  logic [7:0]         req_sig_denominator,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_tick_out,
   output logic [30:0]        rsp_measure_out,
   output logic [30:0]        rsp_beat_out,
   output logic [8:0]         rsp_subtick_out,
   output logic [30:0]        rsp_beats_per_measure
);

`include "time_signature_map_assert.svh"

   tsm_pkg::state_type     state_ff, state_in;
   tsm_pkg::phase_type     phase_ff, phase_in;
   logic [1:0]             func_ff, func_in;
   logic [15:0]            meas_ff, meas_in;
   logic [7:0]             beat_ff, beat_in;
   logic [30:0]            tick_ff, tick_in;
   logic [7:0]             num_ff, num_in;
   logic [7:0]             den_ff, den_in;
   tsm_pkg::count_type     count_ff, count_in;
   tsm_pkg::count_type     idx_ff, idx_in;
   tsm_pkg::sig_entry_type sel_ff, sel_in;
   tsm_pkg::sig_entry_type e0_ff, e0_in;
   logic [23:0]            prod_ff, prod_in;
   tsm_pkg::divisor_type   len_ff, len_in;
   tsm_pkg::divisor_type   remq_ff, remq_in;
   logic [2:0]             res_status_ff, res_status_in;
   logic [31:0]            res_tick_ff, res_tick_in;
   logic [30:0]            res_meas_ff, res_meas_in;
   logic [30:0]            res_beat_ff, res_beat_in;
   logic [8:0]             res_sub_ff, res_sub_in;
   logic [30:0]            res_bpm_ff, res_bpm_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic [31:0]            rsp_tick_ff, rsp_tick_in;
   logic [30:0]            rsp_meas_ff, rsp_meas_in;
   logic [30:0]            rsp_beat_ff, rsp_beat_in;
   logic [8:0]             rsp_sub_ff, rsp_sub_in;
   logic [30:0]            rsp_bpm_ff, rsp_bpm_in;

   tsm_pkg::sig_entry_type mem [tsm_pkg::MAX_CHANGES];
   tsm_pkg::sig_entry_type mem_q_ff;
   logic                   rd0_ff;
   tsm_pkg::index_type     rd_addr;
   logic                   wr_en;
   tsm_pkg::index_type     wr_addr;
   tsm_pkg::sig_entry_type wr_data;
   tsm_pkg::sig_entry_type entry_rd;
   tsm_pkg::count_type     last_idx;

   tsm_pkg::div_req_type   div_req;
   tsm_pkg::div_rsp_type   div_rsp;

   logic [15:0]            mdiff;
   tsm_pkg::dividend_type  prod_wide;
   logic [32:0]            diff_full;
   logic [31:0]            diff_clamp;
   logic [31:0]            beat_ticks;
   logic [31:0]            quo32;
   logic [31:0]            meas_sum;
   logic                   brk;

   tsm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= mem[rd_addr];
      rd0_ff   <= (rd_addr == '0);
   end

   always_comb begin
      entry_rd   = rd0_ff ? e0_ff : mem_q_ff;
      last_idx   = count_ff - tsm_pkg::count_type'(1);
      mdiff      = (func_ff == tsm_pkg::FUNC_REV) ? 16'd1 : (meas_ff - sel_ff.measure);
      prod_wide  = tsm_pkg::dividend_type'(prod_ff);
      diff_full  = {2'b00, tick_ff} - {sel_ff.start[31], sel_ff.start};
      diff_clamp = diff_full[32] ? 32'd0 : diff_full[31:0];
      beat_ticks = (32'(beat_ff) << 9) - (32'(beat_ff) << 5);
      quo32      = div_rsp.quotient[31:0];
      meas_sum   = 32'(sel_ff.measure) + quo32;
      brk        = (func_ff == tsm_pkg::FUNC_FWD) ? (meas_ff < entry_rd.measure)
                 : ($signed({1'b0, tick_ff}) < $signed(entry_rd.start));

      div_req.start = 1'b0;
      unique case (phase_ff)
         tsm_pkg::PH_SPAN, tsm_pkg::PH_LEN: begin
            div_req.dividend = (prod_wide << 11) - (prod_wide << 7);
            div_req.divisor  = tsm_pkg::divisor_type'(sel_ff.denom);
         end
         tsm_pkg::PH_MEAS: begin
            div_req.dividend = tsm_pkg::dividend_type'(diff_clamp);
            div_req.divisor  = len_ff;
         end
         tsm_pkg::PH_BEAT: begin
            div_req.dividend = tsm_pkg::dividend_type'(remq_ff);
            div_req.divisor  = tsm_pkg::divisor_type'(tsm_pkg::TICKS_PER_BEAT);
         end
         default: begin
            div_req.dividend = tsm_pkg::dividend_type'(len_ff);
            div_req.divisor  = tsm_pkg::divisor_type'(tsm_pkg::TICKS_PER_BEAT);
         end
      endcase

      state_in      = state_ff;
      phase_in      = phase_ff;
      func_in       = func_ff;
      meas_in       = meas_ff;
      beat_in       = beat_ff;
      tick_in       = tick_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      sel_in        = sel_ff;
      e0_in         = e0_ff;
      prod_in       = prod_ff;
      len_in        = len_ff;
      remq_in       = remq_ff;
      res_status_in = res_status_ff;
      res_tick_in   = res_tick_ff;
      res_meas_in   = res_meas_ff;
      res_beat_in   = res_beat_ff;
      res_sub_in    = res_sub_ff;
      res_bpm_in    = res_bpm_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_tick_in   = rsp_tick_ff;
      rsp_meas_in   = rsp_meas_ff;
      rsp_beat_in   = rsp_beat_ff;
      rsp_sub_in    = rsp_sub_ff;
      rsp_bpm_in    = rsp_bpm_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[tsm_pkg::IDX_W-1:0];
      wr_data       = '{measure: meas_ff, num: num_ff, denom: den_ff,
                        start: sel_ff.start + quo32};

      unique case (state_ff)
         tsm_pkg::S_IDLE: begin
            if (req_valid) begin
               func_in       = req_func;
               meas_in       = req_measure_in;
               beat_in       = req_beat_in;
               tick_in       = req_tick_in;
               num_in        = req_sig_numerator;
               den_in        = req_sig_denominator;
               res_status_in = tsm_pkg::ST_OK;
               res_tick_in   = '0;
               res_meas_in   = '0;
               res_beat_in   = '0;
               res_sub_in    = '0;
               res_bpm_in    = '0;
               state_in      = tsm_pkg::S_DECODE;
            end
         end
         tsm_pkg::S_DECODE: begin
            unique case (func_ff)
               tsm_pkg::FUNC_ADD: begin
                  if (num_ff == '0 || den_ff == '0) begin
                     res_status_in = tsm_pkg::ST_ZERO_SIG;
                     state_in      = tsm_pkg::S_DONE;
                  end else if (meas_ff == '0) begin
                     if (count_ff != tsm_pkg::count_type'(1)) begin
                        res_status_in = tsm_pkg::ST_REPEAT;
                     end else begin
                        e0_in = '{measure: 16'd0, num: num_ff, denom: den_ff, start: 32'd0};
                     end
                     state_in = tsm_pkg::S_DONE;
                  end else begin
                     state_in = tsm_pkg::S_ADD_RD;
                  end
               end
               tsm_pkg::FUNC_FWD, tsm_pkg::FUNC_REV: begin
                  idx_in   = '0;
                  sel_in   = e0_ff;
                  state_in = tsm_pkg::S_SCAN_RD;
               end
               default: begin
                  state_in = tsm_pkg::S_DONE;
               end
            endcase
         end
         tsm_pkg::S_ADD_RD: begin
            rd_addr  = last_idx[tsm_pkg::IDX_W-1:0];
            state_in = tsm_pkg::S_ADD_CHK;
         end
         tsm_pkg::S_ADD_CHK: begin
            if (meas_ff <= entry_rd.measure) begin
               res_status_in = tsm_pkg::ST_NOT_INCR;
               state_in      = tsm_pkg::S_DONE;
            end else if (count_ff >= tsm_pkg::count_type'(tsm_pkg::MAX_CHANGES)) begin
               res_status_in = tsm_pkg::ST_FULL;
               state_in      = tsm_pkg::S_DONE;
            end else begin
               sel_in   = entry_rd;
               state_in = tsm_pkg::S_MUL;
            end
         end
         tsm_pkg::S_SCAN_RD: begin
            rd_addr = idx_ff[tsm_pkg::IDX_W-1:0];
            if (idx_ff == count_ff) begin
               state_in = tsm_pkg::S_MUL;
            end else begin
               state_in = tsm_pkg::S_SCAN_CMP;
            end
         end
         tsm_pkg::S_SCAN_CMP: begin
            if (brk) begin
               state_in = tsm_pkg::S_MUL;
            end else begin
               sel_in   = entry_rd;
               idx_in   = idx_ff + tsm_pkg::count_type'(1);
               state_in = tsm_pkg::S_SCAN_RD;
            end
         end
         tsm_pkg::S_MUL: begin
            prod_in  = 24'(mdiff) * 24'(sel_ff.num);
            phase_in = (func_ff == tsm_pkg::FUNC_REV) ? tsm_pkg::PH_LEN : tsm_pkg::PH_SPAN;
            state_in = tsm_pkg::S_DIV_GO;
         end
         tsm_pkg::S_DIV_GO: begin
            div_req.start = 1'b1;
            state_in      = tsm_pkg::S_DIV_WAIT;
         end
         tsm_pkg::S_DIV_WAIT: begin
            if (div_rsp.done) begin
               unique case (phase_ff)
                  tsm_pkg::PH_SPAN: begin
                     if (func_ff == tsm_pkg::FUNC_ADD) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + tsm_pkg::count_type'(1);
                     end else begin
                        res_tick_in = quo32 + sel_ff.start + beat_ticks + 32'(tick_ff);
                     end
                     state_in = tsm_pkg::S_DONE;
                  end
                  tsm_pkg::PH_LEN: begin
                     len_in   = div_rsp.quotient[tsm_pkg::DIVS_W-1:0];
                     phase_in = tsm_pkg::PH_MEAS;
                     state_in = tsm_pkg::S_DIV_GO;
                  end
                  tsm_pkg::PH_MEAS: begin
                     res_meas_in = meas_sum[30:0];
                     remq_in     = div_rsp.remainder;
                     phase_in    = tsm_pkg::PH_BEAT;
                     state_in    = tsm_pkg::S_DIV_GO;
                  end
                  tsm_pkg::PH_BEAT: begin
                     res_beat_in = div_rsp.quotient[30:0];
                     res_sub_in  = div_rsp.remainder[8:0];
                     phase_in    = tsm_pkg::PH_BPM;
                     state_in    = tsm_pkg::S_DIV_GO;
                  end
                  default: begin
                     res_bpm_in = div_rsp.quotient[30:0];
                     state_in   = tsm_pkg::S_DONE;
                  end
               endcase
            end
         end
         default: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_tick_in   = res_tick_ff;
               rsp_meas_in   = res_meas_ff;
               rsp_beat_in   = res_beat_ff;
               rsp_sub_in    = res_sub_ff;
               rsp_bpm_in    = res_bpm_ff;
               state_in      = tsm_pkg::S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsm_pkg::S_IDLE;
         phase_ff     <= tsm_pkg::PH_SPAN;
         count_ff     <= tsm_pkg::count_type'(1);
         e0_ff        <= '{measure: 16'd0, num: 8'd4, denom: 8'd4, start: 32'd0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         e0_ff        <= e0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      meas_ff       <= meas_in;
      beat_ff       <= beat_in;
      tick_ff       <= tick_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      idx_ff        <= idx_in;
      sel_ff        <= sel_in;
      prod_ff       <= prod_in;
      len_ff        <= len_in;
      remq_ff       <= remq_in;
      res_status_ff <= res_status_in;
      res_tick_ff   <= res_tick_in;
      res_meas_ff   <= res_meas_in;
      res_beat_ff   <= res_beat_in;
      res_sub_ff    <= res_sub_in;
      res_bpm_ff    <= res_bpm_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tick_ff   <= rsp_tick_in;
      rsp_meas_ff   <= rsp_meas_in;
      rsp_beat_ff   <= rsp_beat_in;
      rsp_sub_ff    <= rsp_sub_in;
      rsp_bpm_ff    <= rsp_bpm_in;
   end

   assign req_stall             = (state_ff != tsm_pkg::S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_tick_out          = $signed(rsp_tick_ff);
   assign rsp_measure_out       = rsp_meas_ff;
   assign rsp_beat_out          = rsp_beat_ff;
   assign rsp_subtick_out       = rsp_sub_ff;
   assign rsp_beats_per_measure = rsp_bpm_ff;

   `TSM_ASSERT_SAME(a_count_range, 1'b1,
      count_ff != '0 && count_ff <= tsm_pkg::count_type'(tsm_pkg::MAX_CHANGES))
   `TSM_ASSERT_NEXT(a_busy_after_request, req_valid && !req_stall, req_stall)
   `TSM_ASSERT_SAME(a_count_step, count_ff != $past(count_ff),
      count_ff == $past(count_ff) + tsm_pkg::count_type'(1))

endmodule

// File: sim/testbench.sv
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int N_RANDOM = 1500;

   typedef struct {
      logic        pause;
      logic [1:0]  func;
      logic [15:0] measure;
      logic [7:0]  beat;
      logic [30:0] tick;
      logic [7:0]  num;
      logic [7:0]  denom;
   } request_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] tick;
      logic [30:0] measure;
      logic [30:0] beat;
      logic [8:0]  subtick;
      logic [30:0] bpm;
   } answer_type;

   typedef struct {
      logic [15:0] measure;
      logic [7:0]  num;
      logic [7:0]  denom;
      logic [31:0] start;
   } change_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_func = '0;
   logic [15:0] req_measure_in = '0;
   logic [7:0] req_beat_in = '0;
   logic [30:0] req_tick_in = '0;
   logic [7:0] req_sig_numerator = '0;
   logic [7:0] req_sig_denominator = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic signed [31:0] rsp_tick_out;
   logic [30:0] rsp_measure_out;
   logic [30:0] rsp_beat_out;
   logic [8:0] rsp_subtick_out;
   logic [30:0] rsp_beats_per_measure;

   request_type pending[$];
   answer_type expected_answers[$];
   change_type sig_changes[tsm_pkg::MAX_CHANGES];
   int change_total;
   int accepted = 0;
   int errors = 0;
   int mismatches = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   time_signature_map dut (.*);

   always #2 clock = ~clock;

   function automatic logic [31:0] ticks_in_span(change_type c, logic [31:0] measures);
      logic [63:0] p;
      p = 64'(measures) * c.num * tsm_pkg::TICKS_PER_WHOLE;
      return 32'(p / c.denom);
   endfunction

   task automatic apply_request(request_type r, output answer_type a);
      int k;
      longint diff;
      logic [31:0] len;
      change_type c;
      a = '{default: '0};
      k = 0;
      case (r.func)
         tsm_pkg::FUNC_ADD: begin
            c = sig_changes[change_total - 1];
            if (r.num == 0 || r.denom == 0) begin
               a.status = tsm_pkg::ST_ZERO_SIG;
            end else if (r.measure == 0) begin
               if (change_total != 1) begin
                  a.status = tsm_pkg::ST_REPEAT;
               end else begin
                  sig_changes[0] = '{16'd0, r.num, r.denom, 32'd0};
               end
            end else if (r.measure <= c.measure) begin
               a.status = tsm_pkg::ST_NOT_INCR;
            end else if (change_total >= tsm_pkg::MAX_CHANGES) begin
               a.status = tsm_pkg::ST_FULL;
            end else begin
               sig_changes[change_total] = '{r.measure, r.num, r.denom,
                  c.start + ticks_in_span(c, 32'(r.measure - c.measure))};
               change_total++;
            end
         end
         tsm_pkg::FUNC_FWD: begin
            for (int i = 0; i < change_total; i++) begin
               if (r.measure < sig_changes[i].measure) break;
               k = i;
            end
            c = sig_changes[k];
            a.tick = ticks_in_span(c, 32'(r.measure - c.measure)) + c.start
               + r.beat * 32'(tsm_pkg::TICKS_PER_BEAT) + 32'(r.tick);
         end
         tsm_pkg::FUNC_REV: begin
            for (int i = 0; i < change_total; i++) begin
               if (longint'(r.tick) < longint'($signed(sig_changes[i].start))) break;
               k = i;
            end
            c = sig_changes[k];
            len = (32'(c.num) * tsm_pkg::TICKS_PER_WHOLE) / c.denom;
            diff = longint'(r.tick) - longint'($signed(c.start));
            if (diff < 0) diff = 0;
            a.measure = 31'(longint'(c.measure) + diff / len);
            a.beat = 31'((diff % len) / tsm_pkg::TICKS_PER_BEAT);
            a.subtick = 9'((diff % len) % tsm_pkg::TICKS_PER_BEAT);
            a.bpm = 31'(len / tsm_pkg::TICKS_PER_BEAT);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      answer_type a;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            apply_request('{1'b0, req_func, req_measure_in, req_beat_in, req_tick_in,
               req_sig_numerator, req_sig_denominator}, a);
            expected_answers.insert(expected_answers.size(), a);
            accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending.size() > 0 && pending[0].pause && !(req_valid && !req_stall)
                  && expected_answers.size() == 0 && !req_valid)
               void'(pending.pop_front());
            if (pending.size() > 0 && !pending[0].pause
                  && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_func <= pending[0].func;
               req_measure_in <= pending[0].measure;
               req_beat_in <= pending[0].beat;
               req_tick_in <= pending[0].tick;
               req_sig_numerator <= pending[0].num;
               req_sig_denominator <= pending[0].denom;
               void'(pending.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      answer_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               errors++;
               $display("unexpected response at %0t", $realtime);
            end else begin
               e = expected_answers.pop_front();
               if (rsp_status !== e.status || rsp_tick_out !== e.tick
                     || rsp_measure_out !== e.measure || rsp_beat_out !== e.beat
                     || rsp_subtick_out !== e.subtick || rsp_beats_per_measure !== e.bpm)
                     begin
                  errors++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("expected %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                        e.status, $signed(e.tick), e.measure, e.beat, e.subtick, e.bpm,
                        rsp_status, rsp_tick_out, rsp_measure_out, rsp_beat_out,
                        rsp_subtick_out, rsp_beats_per_measure);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      case ((accepted / 200) % 4)
         0: begin sender_idle_pct <= 0;  receiver_stall_pct <= 0;  end
         1: begin sender_idle_pct <= 63; receiver_stall_pct <= 0;  end
         2: begin sender_idle_pct <= 0;  receiver_stall_pct <= 63; end
         default: begin sender_idle_pct <= 27; receiver_stall_pct <= 27; end
      endcase
   end

   task automatic queue_request(logic [1:0] f, logic [15:0] m, logic [7:0] b,
         logic [30:0] t, logic [7:0] n, logic [7:0] d);
      pending.insert(pending.size(), request_type'{1'b0, f, m, b, t, n, d});
   endtask

   task automatic queue_pause();
      pending.insert(pending.size(), request_type'{1'b1, FUNC_NONE, 0, 0, 0, 0, 0});
   endtask

   initial begin
      int last_measure;
      int sel;
      int m;
      change_total = 1;
      sig_changes[0] = '{16'd0, 8'd4, 8'd4, 32'd0};
      queue_request(tsm_pkg::FUNC_REV, 0, 0, 31'h7fffffff, 0, 0);
      queue_request(tsm_pkg::FUNC_FWD, 16'hffff, 8'hff, 31'h7fffffff, 0, 0);
      queue_request(tsm_pkg::FUNC_ADD, 5, 0, 0, 0, 4);
      queue_request(tsm_pkg::FUNC_ADD, 5, 0, 0, 3, 0);
      queue_request(tsm_pkg::FUNC_ADD, 0, 0, 0, 3, 8);
      queue_request(tsm_pkg::FUNC_ADD, 0, 0, 0, 8'hff, 8'h01);
      queue_request(tsm_pkg::FUNC_FWD, 16'd100, 8'd3, 31'd17, 0, 0);
      queue_request(tsm_pkg::FUNC_ADD, 0, 0, 0, 7, 8);
      queue_request(tsm_pkg::FUNC_ADD, 10, 0, 0, 1, 8'hff);
      queue_request(tsm_pkg::FUNC_ADD, 0, 0, 0, 4, 4);
      queue_request(tsm_pkg::FUNC_ADD, 10, 0, 0, 4, 4);
      queue_request(tsm_pkg::FUNC_ADD, 9, 0, 0, 4, 4);
      queue_request(tsm_pkg::FUNC_ADD, 20, 0, 0, 8'hff, 8'h01);
      queue_request(tsm_pkg::FUNC_FWD, 15, 2, 100, 0, 0);
      queue_request(tsm_pkg::FUNC_FWD, 0, 0, 0, 0, 0);
      queue_request(tsm_pkg::FUNC_REV, 0, 0, 31'd1000, 0, 0);
      queue_request(tsm_pkg::FUNC_REV, 0, 0, 31'h7fffffff, 0, 0);
      queue_request(FUNC_NONE, 16'hffff, 8'hff, 31'h7fffffff, 8'hff, 8'hff);
      queue_pause();
      last_measure = 20;
      for (int i = 0; i < N_RANDOM; i++) begin
         sel = $urandom_range(99);
         if (i == N_RANDOM / 2) queue_pause();
         if (sel < 25) begin
            m = last_measure + $urandom_range(1, 900);
            if ($urandom_range(9) == 0) m = $urandom_range(65535);
            if (m > 65535) m = 65535;
            queue_request(tsm_pkg::FUNC_ADD, 16'(m), 8'($urandom), 31'($urandom),
               ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
               ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
            if (m > last_measure) last_measure = m;
         end else if (sel < 60) begin
            queue_request(tsm_pkg::FUNC_FWD, ($urandom_range(3) == 0) ? 16'($urandom)
               : 16'($urandom_range(last_measure + 50)), 8'($urandom), 31'($urandom),
               8'($urandom), 8'($urandom));
         end else if (sel < 97) begin
            queue_request(tsm_pkg::FUNC_REV, 16'($urandom), 8'($urandom),
               ($urandom_range(1) == 0) ? 31'($urandom)
               : 31'($urandom_range(4000000)), 8'($urandom), 8'($urandom));
         end else begin
            queue_request(FUNC_NONE, 16'($urandom), 8'($urandom), 31'($urandom),
               8'($urandom), 8'($urandom));
         end
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending.size() == 0 && !req_valid && expected_answers.size() == 0);
      repeat (400) @(posedge clock);
      if (errors == 0 && expected_answers.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
